// ----- hw/rtl/saa_pkg.sv -----
// Shared types, constants and command/status bundles for the shelf atlas allocator.
package saa_pkg;

    localparam int DIM_W           = 10;
    localparam int HQ_W            = 11;
    localparam int AREA_W          = 2 * DIM_W;
    localparam int TEXEL_W         = 26;
    localparam int STATUS_W        = 2;
    localparam int PAGE_IDX_W      = 3;
    localparam int POS_W           = 11;
    localparam int PAGES_OPEN_W    = 4;
    localparam int HEIGHT_QUANT    = 8;
    localparam int DIM_LIMIT_RESET = 512;

    localparam int PAGE_SIZE_DEF        = 2048;
    localparam int MAX_PAGES_DEF        = 8;
    localparam int SHELVES_PER_PAGE_DEF = 128;

    localparam logic [TEXEL_W-1:0] TEXEL_MAX = {TEXEL_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        RES_PLACED = 2'd0,
        RES_REJECT = 2'd1,
        RES_FULL   = 2'd2
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAGE,
        ST_SCAN,
        ST_TAIL,
        ST_NEWPAGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_first;
        logic scan_next;
        logic page_next;
        logic place_hit;
        logic open_shelf;
        logic open_page;
        logic finish;
        res_t res;
    } saa_cmd_t;

    typedef struct packed {
        logic reject;
        logic page_live;
        logic room_pages;
        logic shelf_none;
        logic hit;
        logic last_shelf;
        logic tail_fits;
        logic out_free;
    } saa_sts_t;

endpackage

// ----- hw/rtl/saa_req_if.sv -----
// Request channel: one region size per transaction.
interface saa_req_if;
    logic                      valid;
    logic                      ready;
    logic [saa_pkg::DIM_W-1:0] region_width;
    logic [saa_pkg::DIM_W-1:0] region_height;

    modport source (output valid, output region_width, output region_height, input ready);
    modport sink   (input valid, input region_width, input region_height, output ready);
endinterface

// ----- hw/rtl/saa_rsp_if.sv -----
// Result channel: placement outcome and running totals per transaction.
interface saa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [saa_pkg::STATUS_W-1:0]     status;
    logic [saa_pkg::PAGE_IDX_W-1:0]   page_index;
    logic [saa_pkg::POS_W-1:0]        x_pos;
    logic [saa_pkg::POS_W-1:0]        y_pos;
    logic [saa_pkg::PAGES_OPEN_W-1:0] pages_open;
    logic [saa_pkg::TEXEL_W-1:0]      used_texels_total;

    modport source (output valid, output status, output page_index, output x_pos,
                    output y_pos, output pages_open, output used_texels_total,
                    input ready);
    modport sink   (input valid, input status, input page_index, input x_pos,
                    input y_pos, input pages_open, input used_texels_total,
                    output ready);
endinterface

// ----- hw/rtl/saa_ctrl.sv -----
// Sequencer for the page and shelf search of the atlas allocator.
module saa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  saa_pkg::saa_sts_t sts,
    output saa_pkg::saa_cmd_t cmd
);
    import saa_pkg::*;

    state_t state_reg;
    state_t state_next;
    res_t   res_reg;
    res_t   res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= RES_PLACED;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = ST_PAGE;
                end
            end
            ST_PAGE:
            begin
                if (sts.reject)
                begin
                    res_next   = RES_REJECT;
                    state_next = ST_DONE;
                end
                else if (sts.page_live)
                begin
                    if (sts.shelf_none)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        cmd.scan_first = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
                else if (sts.room_pages)
                begin
                    state_next = ST_NEWPAGE;
                end
                else
                begin
                    res_next   = RES_FULL;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.place_hit = 1'b1;
                    res_next      = RES_PLACED;
                    state_next    = ST_DONE;
                end
                else if (!sts.last_shelf)
                begin
                    cmd.scan_next = 1'b1;
                end
                else
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (sts.tail_fits)
                begin
                    cmd.open_shelf = 1'b1;
                    res_next       = RES_PLACED;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.page_next = 1'b1;
                    state_next    = ST_PAGE;
                end
            end
            ST_NEWPAGE:
            begin
                cmd.open_page = 1'b1;
                res_next      = RES_PLACED;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/saa_dpath.sv -----
// Shelf memory, page bookkeeping, totals and result register of the atlas allocator.
module saa_dpath
#(
    parameter int PAGE_SIZE        = saa_pkg::PAGE_SIZE_DEF,
    parameter int MAX_PAGES        = saa_pkg::MAX_PAGES_DEF,
    parameter int SHELVES_PER_PAGE = saa_pkg::SHELVES_PER_PAGE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [saa_pkg::DIM_W-1:0] region_width,
    input  logic [saa_pkg::DIM_W-1:0] region_height,
    input  logic                      cfg_we,
    input  logic [saa_pkg::DIM_W-1:0] cfg_wdata,
    input  saa_pkg::saa_cmd_t         cmd,
    output saa_pkg::saa_sts_t         sts,
    saa_rsp_if.source                 rsp
);
    import saa_pkg::*;

    localparam int CW    = $clog2(PAGE_SIZE + 1);
    localparam int SUMW  = CW + 1;
    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW   = $clog2(MAX_PAGES + 1);
    localparam int SW    = (SHELVES_PER_PAGE > 1) ? $clog2(SHELVES_PER_PAGE) : 1;
    localparam int SNW   = $clog2(SHELVES_PER_PAGE + 1);
    localparam int SLOTS = MAX_PAGES * SHELVES_PER_PAGE;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW    = 3 * CW;

    localparam logic [SUMW-1:0] PAGE_LIM = SUMW'(PAGE_SIZE);

    function automatic logic [AW-1:0] slot_addr(logic [PCW-1:0] p, logic [SNW-1:0] s);
        return AW'(p) * AW'(SHELVES_PER_PAGE) + AW'(s);
    endfunction

    // shelf word: {top, height class, fill}
    logic [MW-1:0]    shelf_mem [SLOTS];
    logic [MW-1:0]    rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [MW-1:0]    wr_data;

    logic [SNW-1:0]   sip_reg [MAX_PAGES];
    logic [CW-1:0]    nfr_reg [MAX_PAGES];
    logic [PCW-1:0]   page_count_reg;
    logic [TEXEL_W-1:0] texel_reg;
    logic [TEXEL_W-1:0] texel_next;
    logic [DIM_W-1:0] max_dim_reg;

    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;
    logic [HQ_W-1:0]  hq_reg;
    logic             reject_reg;
    logic [AREA_W-1:0] area_reg;
    logic [PCW-1:0]   page_reg;
    logic [SW-1:0]    shelf_reg;

    logic [PW-1:0]    pres_reg;
    logic [CW-1:0]    xres_reg;
    logic [CW-1:0]    yres_reg;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [PAGE_IDX_W-1:0]   out_page_reg;
    logic [POS_W-1:0]        out_x_reg;
    logic [POS_W-1:0]        out_y_reg;
    logic [PAGES_OPEN_W-1:0] out_pages_reg;
    logic [TEXEL_W-1:0]      out_texel_reg;

    logic [HQ_W-1:0]  hq_in;
    logic             reject_in;
    logic [PW-1:0]    pidx;
    logic [PW-1:0]    nidx;
    logic [SNW-1:0]   n_cur;
    logic [CW-1:0]    nfr_cur;
    logic [SNW-1:0]   s_plus;
    logic [CW-1:0]    rd_top;
    logic [CW-1:0]    rd_class;
    logic [CW-1:0]    rd_fill;
    logic [SUMW-1:0]  fill_sum;
    logic [SUMW-1:0]  row_sum;
    logic [CW-1:0]    hq_cw;
    logic [TEXEL_W:0] texel_sum;

    assign hq_in = (HQ_W'(region_height) + HQ_W'(HEIGHT_QUANT - 1))
                   & ~HQ_W'(HEIGHT_QUANT - 1);
    assign reject_in = (region_width == '0) || (region_height == '0)
                    || (region_width > max_dim_reg) || (region_height > max_dim_reg)
                    || (SUMW'(region_width) > PAGE_LIM) || (SUMW'(hq_in) > PAGE_LIM);

    assign pidx     = page_reg[PW-1:0];
    assign nidx     = page_count_reg[PW-1:0];
    assign n_cur    = sip_reg[pidx];
    assign nfr_cur  = nfr_reg[pidx];
    assign s_plus   = SNW'(shelf_reg) + SNW'(1);
    assign hq_cw    = CW'(hq_reg);
    assign rd_top   = rd_data_reg[3*CW-1:2*CW];
    assign rd_class = rd_data_reg[2*CW-1:CW];
    assign rd_fill  = rd_data_reg[CW-1:0];
    assign fill_sum = SUMW'(rd_fill) + SUMW'(w_reg);
    assign row_sum  = SUMW'(nfr_cur) + SUMW'(hq_reg);

    always_comb
    begin
        sts.reject     = reject_reg;
        sts.page_live  = page_reg < page_count_reg;
        sts.room_pages = page_count_reg < PCW'(MAX_PAGES);
        sts.shelf_none = n_cur == '0;
        sts.hit        = (SUMW'(rd_class) == SUMW'(hq_reg)) && (fill_sum <= PAGE_LIM);
        sts.last_shelf = s_plus >= n_cur;
        sts.tail_fits  = (n_cur < SNW'(SHELVES_PER_PAGE)) && (row_sum <= PAGE_LIM);
        sts.out_free   = !out_valid_reg || rsp.ready;
    end

    assign rd_addr = slot_addr(page_reg, cmd.scan_first ? '0 : s_plus);

    always_comb
    begin
        mem_we  = cmd.place_hit || cmd.open_shelf || cmd.open_page;
        wr_addr = slot_addr(page_reg, SNW'(shelf_reg));
        wr_data = {rd_top, rd_class, CW'(fill_sum)};
        if (cmd.open_shelf)
        begin
            wr_addr = slot_addr(page_reg, n_cur);
            wr_data = {nfr_cur, hq_cw, CW'(w_reg)};
        end
        else if (cmd.open_page)
        begin
            wr_addr = slot_addr(page_count_reg, '0);
            wr_data = {CW'(0), hq_cw, CW'(w_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shelf_mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_first || cmd.scan_next)
        begin
            rd_data_reg <= shelf_mem[rd_addr];
        end
    end

    // item payload, search position and placement result
    always_ff @(posedge clk)
    begin
        area_reg <= w_reg * h_reg;
        if (cmd.accept)
        begin
            w_reg      <= region_width;
            h_reg      <= region_height;
            hq_reg     <= hq_in;
            reject_reg <= reject_in;
            page_reg   <= '0;
        end
        else if (cmd.page_next)
        begin
            page_reg <= page_reg + PCW'(1);
        end
        else if (cmd.open_page)
        begin
            page_reg <= page_count_reg;
        end
        if (cmd.scan_first)
        begin
            shelf_reg <= '0;
        end
        else if (cmd.scan_next)
        begin
            shelf_reg <= s_plus[SW-1:0];
        end
        if (cmd.place_hit)
        begin
            pres_reg <= pidx;
            xres_reg <= rd_fill;
            yres_reg <= rd_top;
        end
        else if (cmd.open_shelf)
        begin
            pres_reg <= pidx;
            xres_reg <= '0;
            yres_reg <= nfr_cur;
        end
        else if (cmd.open_page)
        begin
            pres_reg <= nidx;
            xres_reg <= '0;
            yres_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                sip_reg[i] <= '0;
                nfr_reg[i] <= '0;
            end
            page_count_reg <= '0;
        end
        else if (cmd.open_shelf)
        begin
            sip_reg[pidx] <= n_cur + SNW'(1);
            nfr_reg[pidx] <= CW'(row_sum);
        end
        else if (cmd.open_page)
        begin
            sip_reg[nidx]  <= SNW'(1);
            nfr_reg[nidx]  <= hq_cw;
            page_count_reg <= page_count_reg + PCW'(1);
        end
    end

    assign texel_sum  = (TEXEL_W + 1)'(texel_reg) + (TEXEL_W + 1)'(area_reg);
    assign texel_next = (texel_sum > (TEXEL_W + 1)'(TEXEL_MAX)) ? TEXEL_MAX
                                                                : texel_sum[TEXEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dim_reg   <= DIM_W'(DIM_LIMIT_RESET);
            texel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_dim_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (cmd.res == RES_PLACED)
                begin
                    texel_reg <= texel_next;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= cmd.res;
            out_pages_reg  <= PAGES_OPEN_W'(page_count_reg);
            if (cmd.res == RES_PLACED)
            begin
                out_page_reg  <= PAGE_IDX_W'(pres_reg);
                out_x_reg     <= POS_W'(xres_reg);
                out_y_reg     <= POS_W'(yres_reg);
                out_texel_reg <= texel_next;
            end
            else
            begin
                out_page_reg  <= '0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_texel_reg <= texel_reg;
            end
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.page_index        = out_page_reg;
    assign rsp.x_pos             = out_x_reg;
    assign rsp.y_pos             = out_y_reg;
    assign rsp.pages_open        = out_pages_reg;
    assign rsp.used_texels_total = out_texel_reg;

    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        page_count_reg <= PCW'(MAX_PAGES))
        else $error("page count beyond limit");

    a_open_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.open_page |-> page_count_reg < PCW'(MAX_PAGES))
        else $error("page opened in full atlas");

    a_texel_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> texel_reg >= $past(texel_reg))
        else $error("texel total decreased");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result without finished transaction");

endmodule

// ----- hw/rtl/shelf_atlas_allocator_unit.sv -----
// Top level of the shelf-packing atlas allocator.
//
//  channel | dir | payload                                                  | accepted when
//  --------+-----+----------------------------------------------------------+----------------------
//  req     | in  | region_width, region_height                              | req.valid & req.ready
//  rsp     | out | status, page_index, x_pos, y_pos, pages_open,            | rsp.valid & rsp.ready
//          |     | used_texels_total                                        |
//  cfg     | in  | cfg_wdata (max_region_dim)                               | cfg_we
//
// One transaction at a time. A rejected size passes the page and done states before its result is
// registered; a search visits each page in turn, reads its shelves one by one from shelf memory,
// checks the page tail, opens a new page where one opens, and then registers the result.
// Reset clears page bookkeeping and totals at once; the shelf memory needs no clearing pass.
// A finished result waits in the output register while the next request is accepted;
// the search completes and holds until that register frees.
module shelf_atlas_allocator_unit
#(
    parameter int PAGE_SIZE        = saa_pkg::PAGE_SIZE_DEF,
    parameter int MAX_PAGES        = saa_pkg::MAX_PAGES_DEF,
    parameter int SHELVES_PER_PAGE = saa_pkg::SHELVES_PER_PAGE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    saa_req_if.sink                   req,
    saa_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [saa_pkg::DIM_W-1:0] cfg_wdata
);
    import saa_pkg::*;

    saa_cmd_t cmd;
    saa_sts_t sts;
    logic     req_ready;

    assign req.ready = req_ready;

    saa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    saa_dpath
    #(
        .PAGE_SIZE        (PAGE_SIZE),
        .MAX_PAGES        (MAX_PAGES),
        .SHELVES_PER_PAGE (SHELVES_PER_PAGE)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .region_width  (req.region_width),
        .region_height (req.region_height),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .sts           (sts),
        .rsp           (rsp)
    );

endmodule
